/* rtl/rmsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rmsd_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned SumBits    = 32;
  localparam int unsigned SqBits     = 48;
  localparam int unsigned StepBits   = 6;

  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindStart  = 2'd1;
  localparam logic [1:0] KindCancel = 2'd2;

  localparam logic [1:0] StatusRunning = 2'd0;
  localparam logic [1:0] StatusSuccess = 2'd1;
  localparam logic [1:0] StatusAborted = 2'd2;

  localparam logic [0:0] RegGoal      = 1'd0;
  localparam logic [0:0] RegThreshold = 1'd1;

  localparam logic [15:0] ThresholdReset = 16'd1280;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEANSQ,
    ST_SQRT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic accum;
    logic div_start;
    logic div_step;
    logic meansq;
    logic sqrt_start;
    logic sqrt_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/rmsd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmsd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          kind_i,
  input  wire logic                active_i,
  input  wire logic                count_full_i,
  input  wire logic                out_free_i,
  input  wire rmsd_pkg::stat_t     stat_i,
  output logic                     in_ready_o,
  output rmsd_pkg::cmd_t           cmd_o
);

  rmsd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rmsd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == rmsd_pkg::KindStart) begin
            cmd_o.clear = 1'b1;
          end else if (kind_i == rmsd_pkg::KindSample && active_i && !count_full_i) begin
            cmd_o.accum = 1'b1;
            state_d     = rmsd_pkg::ST_DIV;
          end
        end
      end
      rmsd_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.div_step  = 1'b0;
          cmd_o.div_start = 1'b1;
          state_d         = rmsd_pkg::ST_MEANSQ;
        end
      end
      rmsd_pkg::ST_MEANSQ: begin
        cmd_o.meansq = 1'b1;
        state_d      = rmsd_pkg::ST_SQRT;
      end
      rmsd_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_done) begin
          state_d = rmsd_pkg::ST_OUT;
        end
      end
      rmsd_pkg::ST_OUT: begin
        if (out_free_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = rmsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmsd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rmsd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// Datapath: accumulators, two restoring dividers sharing one counter
// (sum and sum of squares by count), squared mean, bit-pair square root.
module rmsd_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rmsd_pkg::cmd_t        cmd_i,
  input  wire logic                  kind_cancel_i,
  input  wire logic [15:0]           sample_i,
  input  wire logic [15:0]           goal_i,
  input  wire logic [15:0]           threshold_i,
  output logic                       active_o,
  output logic                       count_full_o,
  output rmsd_pkg::stat_t            stat_o,
  output logic [15:0]                count_o,
  output logic [15:0]                last_o,
  output logic [15:0]                mean_o,
  output logic [15:0]                sd_o,
  output logic [1:0]                 status_o
);

  logic                 active_q;
  logic [15:0]          count_q;
  logic signed [31:0]   sum_q;
  logic [47:0]          sq_q;
  logic [15:0]          last_q;

  // divider state
  logic [5:0]           step_q;
  logic [31:0]          qs_q;   // sum magnitude -> quotient
  logic [16:0]          rs_q;
  logic [47:0]          qq_q;   // square sum -> quotient
  logic [16:0]          rq_q;
  logic                 neg_q;

  logic [15:0]          mean_q;
  logic [47:0]          diff_q;
  logic [23:0]          root_q;
  logic [47:0]          rem_q;
  logic [4:0]           sq_step_q;
  logic [31:0]          mean_sq_q;

  logic signed [15:0]   s_sx;
  logic [15:0]          s_mag;
  logic [31:0]          sq_sample;
  logic signed [31:0]   sum_new;
  logic [15:0]          cnt_new;
  logic [16:0]          rs_sh, rq_sh;
  logic [16:0]          cnt_ext;
  logic [15:0]          mean_val;
  logic [15:0]          mean_mag;
  logic [47:0]          msq;
  logic [25:0]          trial;
  logic [47:0]          rem_sh;

  assign s_sx      = signed'(sample_i);
  assign s_mag     = s_sx[15] ? 16'(-s_sx) : sample_i;
  assign sq_sample = s_mag * s_mag;
  assign sum_new   = sum_q + 32'(s_sx);
  assign cnt_new   = count_q + 16'd1;
  assign cnt_ext   = {1'b0, count_q};
  assign rs_sh     = {rs_q[15:0], qs_q[31]};
  assign rq_sh     = {rq_q[15:0], qq_q[47]};
  assign mean_val  = neg_q ? 16'(-qs_q[15:0]) : qs_q[15:0];
  assign mean_mag  = mean_val[15] ? 16'(-mean_val) : mean_val;
  assign msq       = qq_q;
  assign rem_sh    = {rem_q[45:0], diff_q[47:46]};
  assign trial     = {root_q, 2'b01};

  assign stat_o.div_done  = (step_q == 6'd48);
  assign stat_o.sqrt_done = (sq_step_q == 5'd24);
  assign active_o         = active_q;
  assign count_full_o     = (count_q == 16'hFFFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        active_q <= 1'b1;
        count_q  <= '0;
        sum_q    <= '0;
        sq_q     <= '0;
      end else if (kind_cancel_i) begin
        active_q <= 1'b0;
      end else if (cmd_i.accum) begin
        count_q <= cnt_new;
        sum_q   <= sum_new;
        sq_q    <= sq_q + 48'(sq_sample);
      end
      if (cmd_i.load_out && ({16'd0, count_q} > {16'd0, goal_i})) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      last_q <= sample_i;
      step_q <= '0;
      neg_q  <= sum_new[31];
      qs_q   <= sum_new[31] ? 32'(-sum_new) : 32'(sum_new);
      qq_q   <= sq_q + 48'(sq_sample);
      rs_q   <= '0;
      rq_q   <= '0;
    end else if (cmd_i.div_step) begin
      // one restoring step a cycle, 48 steps; the sum magnitude steps once step_q >= 16
      step_q <= step_q + 6'd1;
      if (step_q >= 6'd16) begin
        if (rs_sh >= cnt_ext) begin
          rs_q <= rs_sh - cnt_ext;
          qs_q <= {qs_q[30:0], 1'b1};
        end else begin
          rs_q <= rs_sh;
          qs_q <= {qs_q[30:0], 1'b0};
        end
      end
      if (rq_sh >= cnt_ext) begin
        rq_q <= rq_sh - cnt_ext;
        qq_q <= {qq_q[46:0], 1'b1};
      end else begin
        rq_q <= rq_sh;
        qq_q <= {qq_q[46:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      mean_q <= mean_val;
    end
    if (cmd_i.meansq) begin
      diff_q    <= (msq >= 48'(mean_sq_q)) ? msq - 48'(mean_sq_q) : 48'(mean_sq_q) - msq;
      root_q    <= '0;
      rem_q     <= '0;
      sq_step_q <= '0;
    end else if (cmd_i.sqrt_step && sq_step_q != 5'd24) begin
      sq_step_q <= sq_step_q + 5'd1;
      diff_q    <= {diff_q[45:0], 2'b00};
      if (rem_sh >= 48'(trial)) begin
        rem_q  <= rem_sh - 48'(trial);
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[22:0], 1'b0};
      end
    end
    if (cmd_i.div_start) begin
      mean_sq_q <= {16'd0, mean_mag} * {16'd0, mean_mag};
    end
    if (cmd_i.load_out) begin
      count_o <= count_q;
      last_o  <= last_q;
      mean_o  <= mean_q;
      sd_o    <= root_q[15:0];
      if (count_q > goal_i) begin
        status_o <= ($signed(mean_q) >= $signed(threshold_i)) ?
                    rmsd_pkg::StatusSuccess : rmsd_pkg::StatusAborted;
      end else begin
        status_o <= rmsd_pkg::StatusRunning;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/running_mean_stddev_goal_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Running mean and standard deviation with a sample goal. A start item
// clears the run and makes the block active; a cancel item makes it idle.
// Each sample taken while active yields one result item: the count, and
// the sample, the truncated mean and floor(sqrt(|sumsq/count - mean^2|)),
// these three Q8.8, plus the run status, which leaves running once the
// count exceeds goal_samples. Start, cancel and ignored samples are taken
// in the idle state and give no result. A sample that gives a result
// passes in order through its acceptance, the shared-counter restoring
// divider (48 steps, then latching the mean and its square), the difference
// of mean of squares and squared mean, the bit-pair square root (24 steps,
// then the done state), and the load of the output register, which waits
// until that register is free. The block takes one item at a time; the
// output register holds a result until it is taken, and the next item is
// accepted once the result has moved there.
// Write configuration only while idle: index 0 goal_samples, 1 pass_threshold.
module running_mean_stddev_goal_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      sample_count_o,
  output logic [15:0]      last_sample_o,
  output logic [15:0]      mean_o,
  output logic [15:0]      std_dev_o,
  output logic [1:0]       run_status_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  rmsd_pkg::cmd_t  cmd;
  rmsd_pkg::stat_t stat;
  logic            active, count_full, in_ready, out_free, cancel;
  logic [15:0]     goal_q, threshold_q;
  logic            out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = in_ready;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign cancel      = in_valid_i && in_ready && (kind_i == rmsd_pkg::KindCancel);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q      <= '0;
      threshold_q <= rmsd_pkg::ThresholdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rmsd_pkg::RegGoal:      goal_q      <= cfg_data_i;
        rmsd_pkg::RegThreshold: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  rmsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .active_i    (active),
    .count_full_i(count_full),
    .out_free_i  (out_free),
    .stat_i      (stat),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  rmsd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_cancel_i(cancel),
    .sample_i     (sample_i),
    .goal_i       (goal_q),
    .threshold_i  (threshold_q),
    .active_o     (active),
    .count_full_o (count_full),
    .stat_o       (stat),
    .count_o      (sample_count_o),
    .last_o       (last_sample_o),
    .mean_o       (mean_o),
    .sd_o         (std_dev_o),
    .status_o     (run_status_o)
  );

endmodule
`default_nettype wire

/* rtl/rmsd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] std_dev_o,
  input wire logic [15:0] sample_count_o,
  input wire logic [1:0]  run_status_o
);

  // a shown result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(std_dev_o))
    else $error("result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o != 16'd0)
    else $error("zero count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_status_o == rmsd_pkg::StatusRunning ||
                     run_status_o == rmsd_pkg::StatusSuccess ||
                     run_status_o == rmsd_pkg::StatusAborted))
    else $error("bad status");

  // a freshly shown result follows a cycle without input acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without work");

endmodule

bind running_mean_stddev_goal_top rmsd_checker u_rmsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .std_dev_o     (std_dev_o),
  .sample_count_o(sample_count_o),
  .run_status_o  (run_status_o)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = rmsd_pkg::KindCancel;
  logic [15:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] sample_count_o;
  logic [15:0] last_sample_o;
  logic [15:0] mean_o;
  logic [15:0] std_dev_o;
  logic [1:0]  run_status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = rmsd_pkg::RegGoal;
  logic [15:0] cfg_data_i = '0;

  running_mean_stddev_goal_top uut (.*);

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] smp;
    logic [15:0] mean;
    logic [15:0] sd;
    logic [1:0]  status;
  } stat_result_t;

  // predictor state
  logic [15:0]        goal_q = 16'd0;
  logic signed [15:0] thresh_q = rmsd_pkg::ThresholdReset;
  bit                 run_active = 0;
  longint unsigned    n_taken = 0;
  longint             sum_q = 0;
  longint unsigned    sumsq_q = 0;

  stat_result_t pending_stats[$];
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 0;
  event hold_start;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hold the receiver off when asked, then release it.
  initial begin
    forever begin
      @(hold_start);
      recv_hold = 1'b1;
      repeat (400) @(posedge clk_i);
      recv_hold = 1'b0;
    end
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void predict_stats(logic [1:0] kind, logic signed [15:0] smp);
    longint mag_sum, m, ms, msq, msqm, diff;
    stat_result_t r;
    if (kind == rmsd_pkg::KindStart) begin
      n_taken = 0; sum_q = 0; sumsq_q = 0; run_active = 1;
      return;
    end
    if (kind == rmsd_pkg::KindCancel) begin
      run_active = 0;
      return;
    end
    if (kind != rmsd_pkg::KindSample || !run_active || n_taken >= 65535) return;
    n_taken++;
    sum_q += smp;
    ms = (smp < 0) ? -longint'(smp) : longint'(smp);
    sumsq_q += ms * ms;
    mag_sum = (sum_q < 0) ? -sum_q : sum_q;
    m = mag_sum / longint'(n_taken);
    if (sum_q < 0) m = -m;
    m = longint'($signed(m[15:0]));
    msq = sumsq_q / n_taken;
    msqm = (m < 0 ? -m : m) * (m < 0 ? -m : m);
    diff = msq >= msqm ? msq - msqm : msqm - msq;
    r.status = rmsd_pkg::StatusRunning;
    if (n_taken > goal_q) begin
      r.status = (m >= thresh_q) ? rmsd_pkg::StatusSuccess : rmsd_pkg::StatusAborted;
      run_active = 0;
    end
    r.count = n_taken[15:0];
    r.smp = smp;
    r.mean = m[15:0];
    r.sd = 16'(floor_sqrt(diff));
    pending_stats.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  // Take results, stall at random or during a hold-off, check against the oldest.
  always @(posedge clk_i) begin
    stat_result_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_stats.size() == 0) begin
          report_mismatch("unexpected item", sample_count_o, 16'h0);
        end else begin
          w = pending_stats.pop_front();
          if (sample_count_o !== w.count) report_mismatch("count", sample_count_o, w.count);
          if (last_sample_o !== w.smp) report_mismatch("sample", last_sample_o, w.smp);
          if (mean_o !== w.mean) report_mismatch("mean", mean_o, w.mean);
          if (std_dev_o !== w.sd) report_mismatch("std_dev", std_dev_o, w.sd);
          if (run_status_o !== w.status)
            report_mismatch("status", {14'd0, run_status_o}, {14'd0, w.status});
        end
      end
      if (recv_hold) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    sample_i <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_stats(kind, smp);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == rmsd_pkg::RegGoal) goal_q = data;
    else thresh_q = data;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic test_directed();
    send_item(rmsd_pkg::KindSample, 16'h1234);        // idle sample is dropped
    send_item(rmsd_pkg::KindCancel, 16'h0);           // cancel while idle
    send_item(2'd3, 16'hffff);                        // kind three
    write_reg(rmsd_pkg::RegGoal, 16'd4);
    write_reg(rmsd_pkg::RegThreshold, 16'h8000);
    send_item(rmsd_pkg::KindStart, 16'h0);
    send_item(rmsd_pkg::KindSample, 16'h7fff);
    send_item(rmsd_pkg::KindSample, 16'h8000);
    send_item(rmsd_pkg::KindStart, 16'h0);            // restart mid-run
    send_item(rmsd_pkg::KindSample, 16'h8000);
    send_item(rmsd_pkg::KindSample, 16'h8000);
    send_item(rmsd_pkg::KindSample, 16'h0000);
    send_item(rmsd_pkg::KindSample, 16'hffff);
    send_item(rmsd_pkg::KindSample, 16'h0001);        // goal reached
    send_item(rmsd_pkg::KindSample, 16'h0500);        // ignored after finish
    drain();
    write_reg(rmsd_pkg::RegThreshold, 16'h7fff);
    write_reg(rmsd_pkg::RegGoal, 16'd0);
    send_item(rmsd_pkg::KindStart, 16'h0);
    send_item(rmsd_pkg::KindSample, 16'h7fff);
    send_item(rmsd_pkg::KindStart, 16'h0);
    send_item(rmsd_pkg::KindSample, 16'h0);
    send_item(rmsd_pkg::KindStart, 16'h0);
    send_item(rmsd_pkg::KindCancel, 16'h0);
    send_item(rmsd_pkg::KindSample, 16'h0100);
    drain();
  endtask

  task automatic test_random_runs(int n_items, int goal_max);
    int k;
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      if (k < 4) send_item(rmsd_pkg::KindStart, 16'($urandom));
      else if (k < 6) send_item(rmsd_pkg::KindCancel, 16'($urandom));
      else if (k < 7) send_item(2'd3, 16'($urandom));
      else if (!run_active && k < 40) send_item(rmsd_pkg::KindStart, 16'h0);
      else send_item(rmsd_pkg::KindSample, rand_sample());
    end
    drain();
    write_reg(rmsd_pkg::RegGoal, 16'($urandom_range(goal_max)));
    write_reg(rmsd_pkg::RegThreshold, 16'($urandom));
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits.
  task automatic test_backpressure();
    write_reg(rmsd_pkg::RegGoal, 16'd65534);
    -> hold_start;
    send_item(rmsd_pkg::KindStart, 16'h0);
    for (int i = 0; i < 10; i++) send_item(rmsd_pkg::KindSample, rand_sample());
    drain();
    send_item(rmsd_pkg::KindSample, 16'h7fff);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 11; recv_idle_pct = 60;
    test_random_runs(330, 30);
    test_backpressure();
    send_idle_pct = 60; recv_idle_pct = 11;
    test_random_runs(330, 65534);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_runs(330, 8);
    drain();
    if (n_errors == 0 && pending_stats.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end
endmodule
